/* rtl/vpi_pkg.sv */
// shared types, constants and command codes for the velocity pi block
`timescale 1ns / 1ps
package vpi_pkg;

  localparam int AngleBits = 16;
  localparam int DataWidth = 32;
  localparam int AddrWidth = 5;

  // register byte addresses
  localparam logic [AddrWidth-1:0] AddrPllKp   = 5'd0;
  localparam logic [AddrWidth-1:0] AddrPllKi   = 5'd4;
  localparam logic [AddrWidth-1:0] AddrVelKp   = 5'd8;
  localparam logic [AddrWidth-1:0] AddrVelKi   = 5'd12;
  localparam logic [AddrWidth-1:0] AddrCurLim  = 5'd16;
  localparam logic [AddrWidth-1:0] AddrTickPer = 5'd20;

  localparam logic [22:0] CurLimReset  = 23'd1000;
  localparam logic [31:0] TickPerReset = 32'd429497;

  typedef struct packed {
    logic signed [AngleBits-1:0] angle_measured;
    logic                        angle_ok;
    logic signed [31:0]          velocity_ref;
    logic                        clear_integrators;
  } vpi_in_t;

  typedef struct packed {
    logic signed [23:0]          current_ref;
    logic signed [AngleBits-1:0] angle_estimate;
    logic signed [31:0]          velocity_estimate;
    logic signed [31:0]          velocity_error;
    logic                        current_limited;
    logic                        loop_updated;
  } vpi_out_t;

  typedef struct packed {
    logic [31:0] pll_kp;
    logic [31:0] pll_ki;
    logic [31:0] vel_kp;
    logic [31:0] vel_ki;
    logic [22:0] cur_lim;
    logic [31:0] tick_per;
  } vpi_cfg_t;

  // datapath steps issued by the controller states
  typedef enum logic [3:0] {
    CmdNone,
    CmdLoad,    // capture input, clear, prime
    CmdErrPll,  // pll angle error
    CmdMulPi,   // product e_pll * ki
    CmdAccPi,   // pll integral update
    CmdMulPp,   // product e_pll * kp
    CmdSpeed,   // speed estimate
    CmdMulT,    // product speed * tick period
    CmdAngle,   // angle update, velocity error
    CmdMulVi,   // product e_vel * ki
    CmdAccVi,   // current integral update
    CmdMulVp,   // product e_vel * kp
    CmdSum,     // sum and clamp
    CmdHold     // invalid angle result
  } vpi_cmd_e;

  typedef enum logic [3:0] {
    StIdle, StErrPll, StMulPi, StAccPi, StMulPp, StSpeed, StMulT, StAngle,
    StMulVi, StAccVi, StMulVp, StSum, StOut
  } vpi_state_e;

  typedef struct packed {
    vpi_cmd_e cmd;
    logic     out_load;
  } vpi_ctl_t;

  typedef struct packed {
    logic angle_ok;
  } vpi_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* rtl/vpi_regs.sv */
// apb register file for gains, limit and tick period
`timescale 1ns / 1ps
module vpi_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vpi_pkg::AddrWidth-1:0]   paddr,
  input  logic [vpi_pkg::DataWidth-1:0]   pwdata,
  output logic [vpi_pkg::DataWidth-1:0]   prdata,
  output logic                            pready,
  output vpi_pkg::vpi_cfg_t               cfg_o
);
  import vpi_pkg::*;

  vpi_cfg_t cfg_q;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pll_kp   <= '0;
      cfg_q.pll_ki   <= '0;
      cfg_q.vel_kp   <= '0;
      cfg_q.vel_ki   <= '0;
      cfg_q.cur_lim  <= CurLimReset;
      cfg_q.tick_per <= TickPerReset;
    end else if (wr_en) begin
      unique case (paddr)
        AddrPllKp:   cfg_q.pll_kp   <= pwdata;
        AddrPllKi:   cfg_q.pll_ki   <= pwdata;
        AddrVelKp:   cfg_q.vel_kp   <= pwdata;
        AddrVelKi:   cfg_q.vel_ki   <= pwdata;
        AddrCurLim:  cfg_q.cur_lim  <= pwdata[22:0];
        AddrTickPer: cfg_q.tick_per <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr)
      AddrPllKp:   prdata = cfg_q.pll_kp;
      AddrPllKi:   prdata = cfg_q.pll_ki;
      AddrVelKp:   prdata = cfg_q.vel_kp;
      AddrVelKi:   prdata = cfg_q.vel_ki;
      AddrCurLim:  prdata = {9'd0, cfg_q.cur_lim};
      AddrTickPer: prdata = cfg_q.tick_per;
      default:     prdata = '0;
    endcase
  end
endmodule

/* rtl/vpi_ctrl.sv */
// controller sequencing one request through the shared multiplier
`timescale 1ns / 1ps
module vpi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  vpi_pkg::vpi_sts_t sts_i,
  output vpi_pkg::vpi_ctl_t ctl_o
);
  import vpi_pkg::*;

  vpi_state_e state_q, state_d;
  logic       ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign in_stall_o  = (state_q != StIdle);

  // next state and datapath commands
  always_comb begin
    state_d      = state_q;
    ov_d         = ov_q & out_stall_i;
    ctl_o.cmd    = CmdNone;
    ctl_o.out_load = 1'b0;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        ctl_o.cmd = CmdLoad;
        state_d   = StErrPll;
      end
      StErrPll: begin
        if (sts_i.angle_ok) begin
          ctl_o.cmd = CmdErrPll;
          state_d   = StMulPi;
        end else begin
          ctl_o.cmd = CmdHold;
          state_d   = StOut;
        end
      end
      StMulPi: begin ctl_o.cmd = CmdMulPi; state_d = StAccPi; end
      StAccPi: begin ctl_o.cmd = CmdAccPi; state_d = StMulPp; end
      StMulPp: begin ctl_o.cmd = CmdMulPp; state_d = StSpeed; end
      StSpeed: begin ctl_o.cmd = CmdSpeed; state_d = StMulT; end
      StMulT:  begin ctl_o.cmd = CmdMulT;  state_d = StAngle; end
      StAngle: begin ctl_o.cmd = CmdAngle; state_d = StMulVi; end
      StMulVi: begin ctl_o.cmd = CmdMulVi; state_d = StAccVi; end
      StAccVi: begin ctl_o.cmd = CmdAccVi; state_d = StMulVp; end
      StMulVp: begin ctl_o.cmd = CmdMulVp; state_d = StSum; end
      StSum:   begin ctl_o.cmd = CmdSum;   state_d = StOut; end
      StOut: if (!ov_q || !out_stall_i) begin
        ctl_o.out_load = 1'b1;
        ov_d           = 1'b1;
        state_d        = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

/* rtl/vpi_dp.sv */
// datapath: state registers, shared 33x32 multiplier and rounding
`timescale 1ns / 1ps
module vpi_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vpi_pkg::vpi_in_t  in_i,
  input  vpi_pkg::vpi_cfg_t cfg_i,
  input  vpi_pkg::vpi_ctl_t ctl_i,
  output vpi_pkg::vpi_sts_t sts_o,
  output vpi_pkg::vpi_out_t out_o
);
  import vpi_pkg::*;

  // control state
  logic signed [AngleBits-1:0] angle_est_q, angle_est_d;
  logic signed [31:0]          speed_q, speed_d, pll_int_q, pll_int_d;
  logic signed [31:0]          cur_int_q, cur_int_d;
  logic                        primed_q, primed_d;
  logic signed [23:0]          held_q, held_d;
  // working registers
  vpi_in_t                     req_q;
  logic signed [AngleBits-1:0] e_pll_q;
  logic signed [31:0]          e_vel_q, old_int_q, pterm_q, prod_sat_q;
  logic signed [23:0]          cur_q;
  logic                        lim_q;
  vpi_out_t                    out_q;
  // multiplier operands
  logic signed [32:0]          mul_a;
  logic        [31:0]          mul_g;
  logic                        shift32;
  logic signed [65:0]          prod, rnd;
  logic signed [31:0]          prod_sat;
  logic signed [AngleBits-1:0] meas;
  logic signed [33:0]          sum;
  logic signed [33:0]          limq8;
  logic signed [23:0]          cur_round;
  logic signed [33:0]          sum_r;

  assign meas           = in_i.angle_measured;
  assign sts_o.angle_ok = req_q.angle_ok;
  assign out_o          = out_q;

  // operand select for the shared multiplier
  always_comb begin
    shift32 = 1'b0;
    unique case (ctl_i.cmd)
      CmdMulPi: begin mul_a = 33'(e_pll_q); mul_g = cfg_i.pll_ki; end
      CmdMulPp: begin mul_a = 33'(e_pll_q); mul_g = cfg_i.pll_kp; end
      CmdMulT: begin
        mul_a = 33'(speed_q); mul_g = cfg_i.tick_per; shift32 = 1'b1;
      end
      CmdMulVi: begin mul_a = 33'(e_vel_q); mul_g = cfg_i.vel_ki; end
      default:  begin mul_a = 33'(e_vel_q); mul_g = cfg_i.vel_kp; end
    endcase
  end

  // product, round half up at the shift, saturate
  assign prod = 66'(mul_a) * $signed({34'd0, mul_g});
  always_comb begin
    if (shift32) rnd = (prod + 66'sh80000000) >>> 32;
    else         rnd = (prod + 66'sh8000) >>> 16;
    prod_sat = sat32(rnd);
  end

  assign sum   = 34'(pterm_q) + 34'(cur_int_q);
  assign limq8 = $signed({3'd0, cfg_i.cur_lim, 8'd0});
  assign sum_r = (sum + 34'sd128) >>> 8;
  assign cur_round = sum_r[23:0];

  // state update per command
  always_comb begin
    angle_est_d = angle_est_q;
    speed_d     = speed_q;
    pll_int_d   = pll_int_q;
    cur_int_d   = cur_int_q;
    primed_d    = primed_q;
    held_d      = held_q;
    unique case (ctl_i.cmd)
      CmdLoad: if (in_i.clear_integrators) begin
        pll_int_d = '0;
        cur_int_d = '0;
        primed_d  = 1'b0;
        if (in_i.angle_ok) begin
          angle_est_d = meas; speed_d = '0; primed_d = 1'b1;
        end
      end else if (in_i.angle_ok && !primed_q) begin
        angle_est_d = meas; speed_d = '0; pll_int_d = '0; primed_d = 1'b1;
      end
      CmdAccPi: pll_int_d = sat32(66'(pll_int_q) + 66'(prod_sat_q));
      CmdSpeed: speed_d   = sat32(66'(prod_sat_q) + 66'(pll_int_q));
      CmdAngle: angle_est_d = angle_est_q + prod_sat_q[AngleBits-1:0];
      CmdAccVi: cur_int_d = sat32(66'(cur_int_q) + 66'(prod_sat_q));
      CmdSum: begin
        if (sum > limq8 || sum < -limq8) begin
          cur_int_d = old_int_q;
          held_d    = (sum > limq8) ? $signed({1'b0, cfg_i.cur_lim})
                                    : -$signed({1'b0, cfg_i.cur_lim});
        end else begin
          held_d = cur_round;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_est_q <= '0;
      speed_q     <= '0;
      pll_int_q   <= '0;
      cur_int_q   <= '0;
      primed_q    <= 1'b0;
      held_q      <= '0;
    end else begin
      angle_est_q <= angle_est_d;
      speed_q     <= speed_d;
      pll_int_q   <= pll_int_d;
      cur_int_q   <= cur_int_d;
      primed_q    <= primed_d;
      held_q      <= held_d;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == CmdLoad) req_q <= in_i;
    if (ctl_i.cmd == CmdErrPll)
      e_pll_q <= req_q.angle_measured - angle_est_q;
    if (ctl_i.cmd == CmdMulPi || ctl_i.cmd == CmdMulPp || ctl_i.cmd == CmdMulT ||
        ctl_i.cmd == CmdMulVi)
      prod_sat_q <= prod_sat;
    if (ctl_i.cmd == CmdAngle) begin
      e_vel_q   <= sat32(66'(req_q.velocity_ref) - 66'(speed_q));
      old_int_q <= cur_int_q;
    end
    if (ctl_i.cmd == CmdMulVp) pterm_q <= prod_sat;
    if (ctl_i.cmd == CmdSum) begin
      lim_q <= (sum > limq8 || sum < -limq8);
      cur_q <= held_d;
    end
    if (ctl_i.cmd == CmdHold) begin
      lim_q   <= 1'b0;
      cur_q   <= held_q;
      e_vel_q <= '0;
    end
    if (ctl_i.out_load) begin
      out_q.current_ref       <= cur_q;
      out_q.angle_estimate    <= angle_est_q;
      out_q.velocity_estimate <= speed_q;
      out_q.velocity_error    <= e_vel_q;
      out_q.current_limited   <= lim_q;
      out_q.loop_updated      <= req_q.angle_ok;
    end
  end
endmodule

/* rtl/velocity_pi_with_pll_observer_top.sv */
// Velocity PI controller with PI phase-locked-loop speed observer. One request
// (measured angle, valid flag, velocity reference, clear flag) yields one
// result: clamped current reference, angle and speed estimates, velocity
// error and status flags. A request with a valid angle passes the error step,
// the five products that share one multiplier in sequence and the accumulate,
// clamp and load steps before its result is in the output register; an
// invalid angle goes from the error step straight to the load step. The next
// request is accepted once the result is registered, not while one is in
// progress. While an earlier result still waits in the output register the
// next request is accepted and computed, but it holds in its last step until
// the output register is free. Registers must be written through the APB port
// only while no request is in progress; the block does not enforce this.
`timescale 1ns / 1ps
module velocity_pi_with_pll_observer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  vpi_pkg::vpi_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output vpi_pkg::vpi_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vpi_pkg::AddrWidth-1:0] paddr,
  input  logic [vpi_pkg::DataWidth-1:0] pwdata,
  output logic [vpi_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import vpi_pkg::*;

  vpi_cfg_t cfg;
  vpi_ctl_t ctl;
  vpi_sts_t sts;

  vpi_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready, .cfg_o(cfg)
  );

  vpi_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  vpi_dp u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cfg_i(cfg), .ctl_i(ctl),
    .sts_o(sts), .out_o(out_data_o)
  );
endmodule
